// File: hw/rtl/owb_pkg.sv
package owb_pkg;

	localparam int TIMER_BITS_DEF = 10;
	localparam int REG_W          = 10;
	localparam int NUM_REGS       = 7;
	localparam int CFG_IDX_W      = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESET_LOW   = 3'd0,
		REG_PRES_WAIT   = 3'd1,
		REG_WR_SLOT     = 3'd2,
		REG_START_PULSE = 3'd3,
		REG_RD_SAMPLE   = 3'd4,
		REG_RD_RECOVERY = 3'd5,
		REG_BIT_RECOVERY = 3'd6
	} reg_idx_t;

	localparam logic [REG_W-1:0] RST_RESET_LOW    = 10'd600;
	localparam logic [REG_W-1:0] RST_PRES_WAIT    = 10'd80;
	localparam logic [REG_W-1:0] RST_WR_SLOT      = 10'd80;
	localparam logic [REG_W-1:0] RST_START_PULSE  = 10'd1;
	localparam logic [REG_W-1:0] RST_RD_SAMPLE    = 10'd10;
	localparam logic [REG_W-1:0] RST_RD_RECOVERY  = 10'd50;
	localparam logic [REG_W-1:0] RST_BIT_RECOVERY = 10'd1;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_RESET = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [9:0] {
		PH_IDLE     = 10'b00_0000_0001,
		PH_RST_LOW  = 10'b00_0000_0010,
		PH_RST_WAIT = 10'b00_0000_0100,
		PH_RST_HOLD = 10'b00_0000_1000,
		PH_WR_START = 10'b00_0001_0000,
		PH_WR_SLOT  = 10'b00_0010_0000,
		PH_WR_REC   = 10'b00_0100_0000,
		PH_RD_START = 10'b00_1000_0000,
		PH_RD_WAIT  = 10'b01_0000_0000,
		PH_RD_REC   = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [REG_W-1:0] reset_low_time;
		logic [REG_W-1:0] presence_wait_time;
		logic [REG_W-1:0] write_slot_time;
		logic [REG_W-1:0] start_pulse_time;
		logic [REG_W-1:0] read_sample_time;
		logic [REG_W-1:0] read_recovery_time;
		logic [REG_W-1:0] bit_recovery_time;
	} cfg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] write_byte;
		logic       bus_level;
	} cmd_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_byte;
		logic       rejected;
	} res_t;

endpackage

// File: hw/rtl/owb_if.sv
interface owb_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] write_byte;
	logic       bus_level;

	modport source (output valid, output action, output write_byte, output bus_level,
		input ready);
	modport sink (input valid, input action, input write_byte, input bus_level,
		output ready);
endinterface

interface owb_res_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       presence;
	logic [7:0] read_byte;
	logic       rejected;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output presence, output read_byte, output rejected, input ready);
	modport sink (input valid, input drive_low, input busy_res, input done_res,
		input presence, input read_byte, input rejected, output ready);
endinterface

// File: hw/rtl/one_wire_bus_master_top.sv
// 1-Wire bus master stepped by tick items: every transfer on cmd is one bus tick
// (normally one microsecond) carrying the command, the byte to write and the bus
// level sampled during that tick, and it yields exactly one transfer on res with
// the drive for that tick plus busy, done, presence, read byte and rejected flags.
// The block takes one tick per clock cycle while res does not stall. A tick's
// transfer loads the input register, and the result register loads from it once
// that register is free or being taken; the result then shows on res. The
// sequencer's combinational next-state logic sets that rate. Backpressure on res
// stalls cmd only when both registers are full. The user must write the timing
// registers through cfg_we/cfg_idx/cfg_data only while no operation is running;
// the block does not enforce this. Indexes past the last register are dropped.
module one_wire_bus_master_top #(
	parameter int TIMER_BITS = owb_pkg::TIMER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	owb_cmd_if.sink                        cmd,
	owb_res_if.source                      res,
	input  logic                           cfg_we,
	input  logic [owb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [owb_pkg::REG_W-1:0]      cfg_data
);

	owb_pkg::cfg_t cfg_q;
	owb_pkg::cmd_t cmd_s1;
	logic          valid_s1;
	owb_pkg::res_t res_c, res_q;
	logic          res_valid_q;
	logic          advance;

	// Move the held tick into the result register when that slot is free or
	// being taken this cycle.
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	// Timing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time     <= owb_pkg::RST_RESET_LOW;
			cfg_q.presence_wait_time <= owb_pkg::RST_PRES_WAIT;
			cfg_q.write_slot_time    <= owb_pkg::RST_WR_SLOT;
			cfg_q.start_pulse_time   <= owb_pkg::RST_START_PULSE;
			cfg_q.read_sample_time   <= owb_pkg::RST_RD_SAMPLE;
			cfg_q.read_recovery_time <= owb_pkg::RST_RD_RECOVERY;
			cfg_q.bit_recovery_time  <= owb_pkg::RST_BIT_RECOVERY;
		end else if (cfg_we) begin
			case (cfg_idx)
				owb_pkg::REG_RESET_LOW:    cfg_q.reset_low_time     <= cfg_data;
				owb_pkg::REG_PRES_WAIT:    cfg_q.presence_wait_time <= cfg_data;
				owb_pkg::REG_WR_SLOT:      cfg_q.write_slot_time    <= cfg_data;
				owb_pkg::REG_START_PULSE:  cfg_q.start_pulse_time   <= cfg_data;
				owb_pkg::REG_RD_SAMPLE:    cfg_q.read_sample_time   <= cfg_data;
				owb_pkg::REG_RD_RECOVERY:  cfg_q.read_recovery_time <= cfg_data;
				owb_pkg::REG_BIT_RECOVERY: cfg_q.bit_recovery_time  <= cfg_data;
				default: ; // drop writes past the last register
			endcase
		end
	end

	// Input register: capture each tick on its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1.action     <= cmd.action;
			cmd_s1.write_byte <= cmd.write_byte;
			cmd_s1.bus_level  <= cmd.bus_level;
		end
	end

	// Sequencer: advances its state exactly once per tick.
	owb_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cmd    (cmd_s1),
		.cfg    (cfg_q),
		.res    (res_c)
	);

	// Result register: hold until taken, refill in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.drive_low = res_q.drive_low;
	assign res.busy_res  = res_q.busy_res;
	assign res.done_res  = res_q.done_res;
	assign res.presence  = res_q.presence;
	assign res.read_byte = res_q.read_byte;
	assign res.rejected  = res_q.rejected;

endmodule

// File: hw/rtl/owb_core.sv
module owb_core #(
	parameter int TIMER_BITS = owb_pkg::TIMER_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  owb_pkg::cmd_t  cmd,
	input  owb_pkg::cfg_t  cfg,
	output owb_pkg::res_t  res
);

	localparam int LW = (TIMER_BITS > owb_pkg::REG_W) ? TIMER_BITS : owb_pkg::REG_W;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
	localparam logic [LW-1:0] TMAX_W = LW'(TMAX);

	owb_pkg::phase_t        phase_q, ph_e, ph_n;
	logic [TIMER_BITS-1:0]  timer_q, tmr_e, tmr_n, tmr_inc;
	logic [2:0]             bidx_q, bidx_e, bidx_n;
	logic [7:0]             sb_q, sb_e, sb_n;
	logic                   pres_q, pres_e, pres_n;
	logic [1:0]             op_q, op_e;
	logic                   start, fin;
	logic [owb_pkg::REG_W-1:0] len_raw;
	logic [LW-1:0]          len_w, limit;
	logic [2:0]             bidx_inc;

	// Start a command from idle; the start item is already the first tick.
	always_comb begin
		start  = (phase_q == owb_pkg::PH_IDLE) && (cmd.action != owb_pkg::ACT_TICK);
		ph_e   = phase_q;
		tmr_e  = timer_q;
		bidx_e = bidx_q;
		sb_e   = sb_q;
		pres_e = pres_q;
		op_e   = op_q;
		if (start) begin
			op_e  = cmd.action;
			tmr_e = '0;
			case (cmd.action)
				owb_pkg::ACT_RESET: begin
					pres_e = 1'b0;
					ph_e   = owb_pkg::PH_RST_LOW;
				end
				owb_pkg::ACT_WRITE: begin
					sb_e   = cmd.write_byte;
					bidx_e = '0;
					ph_e   = cmd.write_byte[0] ? owb_pkg::PH_WR_START : owb_pkg::PH_WR_SLOT;
				end
				default: begin
					sb_e   = '0;
					bidx_e = '0;
					ph_e   = owb_pkg::PH_RD_START;
				end
			endcase
		end
	end

	// Phase length: zero counts as one tick, clamp at the timer maximum.
	always_comb begin
		case (ph_e)
			owb_pkg::PH_RST_LOW:  len_raw = cfg.reset_low_time;
			owb_pkg::PH_RST_WAIT: len_raw = cfg.presence_wait_time;
			owb_pkg::PH_WR_SLOT:  len_raw = cfg.write_slot_time;
			owb_pkg::PH_WR_START,
			owb_pkg::PH_RD_START: len_raw = cfg.start_pulse_time;
			owb_pkg::PH_RD_WAIT:  len_raw = cfg.read_sample_time;
			owb_pkg::PH_RD_REC:   len_raw = cfg.read_recovery_time;
			owb_pkg::PH_WR_REC:   len_raw = cfg.bit_recovery_time;
			default:              len_raw = owb_pkg::REG_W'(1);
		endcase
		len_w = (len_raw == '0) ? LW'(1) : LW'(len_raw);
		limit = (len_w > TMAX_W) ? TMAX_W : len_w;
	end

	always_comb begin
		tmr_inc  = (tmr_e != TMAX) ? tmr_e + 1'b1 : tmr_e;
		bidx_inc = bidx_e + 3'd1;
		ph_n     = ph_e;
		tmr_n    = tmr_e;
		bidx_n   = bidx_e;
		sb_n     = sb_e;
		pres_n   = pres_e;
		fin      = 1'b0;
		res      = '0;

		if (ph_e != owb_pkg::PH_IDLE) begin
			case (ph_e)
				owb_pkg::PH_RST_LOW, owb_pkg::PH_WR_START, owb_pkg::PH_RD_START:
					res.drive_low = 1'b1;
				owb_pkg::PH_WR_SLOT:
					res.drive_low = ~sb_e[bidx_e];
				default:
					res.drive_low = 1'b0;
			endcase

			if (ph_e == owb_pkg::PH_RST_HOLD) begin
				fin = cmd.bus_level;
			end else begin
				tmr_n = tmr_inc;
				if (LW'(tmr_inc) >= limit) begin
					tmr_n = '0;
					case (ph_e)
						owb_pkg::PH_RST_LOW:  ph_n = owb_pkg::PH_RST_WAIT;
						owb_pkg::PH_RST_WAIT: begin
							pres_n = ~cmd.bus_level;
							ph_n   = owb_pkg::PH_RST_HOLD;
						end
						owb_pkg::PH_WR_START: ph_n = owb_pkg::PH_WR_SLOT;
						owb_pkg::PH_WR_SLOT:  ph_n = owb_pkg::PH_WR_REC;
						owb_pkg::PH_WR_REC: begin
							if (bidx_e == 3'd7) begin
								fin = 1'b1;
							end else begin
								bidx_n = bidx_inc;
								ph_n   = sb_e[bidx_inc] ? owb_pkg::PH_WR_START
									: owb_pkg::PH_WR_SLOT;
							end
						end
						owb_pkg::PH_RD_START: ph_n = owb_pkg::PH_RD_WAIT;
						owb_pkg::PH_RD_WAIT: begin
							if (cmd.bus_level) sb_n[bidx_e] = 1'b1;
							ph_n = owb_pkg::PH_RD_REC;
						end
						owb_pkg::PH_RD_REC: begin
							if (bidx_e == 3'd7) begin
								fin = 1'b1;
							end else begin
								bidx_n = bidx_inc;
								ph_n   = owb_pkg::PH_RD_START;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end

			if (fin) begin
				res.done_res  = 1'b1;
				res.presence  = (op_e == owb_pkg::ACT_RESET) ? pres_n : 1'b0;
				res.read_byte = (op_e == owb_pkg::ACT_READ) ? sb_n : 8'd0;
				ph_n          = owb_pkg::PH_IDLE;
				tmr_n         = '0;
			end
		end

		res.busy_res = (ph_n != owb_pkg::PH_IDLE);
		res.rejected = (phase_q != owb_pkg::PH_IDLE) && (cmd.action != owb_pkg::ACT_TICK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owb_pkg::PH_IDLE;
			timer_q <= '0;
			bidx_q  <= '0;
			sb_q    <= '0;
			pres_q  <= 1'b0;
			op_q    <= '0;
		end else if (en) begin
			phase_q <= ph_n;
			timer_q <= tmr_n;
			bidx_q  <= bidx_n;
			sb_q    <= sb_n;
			pres_q  <= pres_n;
			op_q    <= op_e;
		end
	end

	// A started command never finishes on its own start tick.
	a_start_stays_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(en && start) |=> (phase_q != owb_pkg::PH_IDLE))
		else $error("command finished on its start tick");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(en && res.done_res) |=> (phase_q == owb_pkg::PH_IDLE))
		else $error("phase not idle after done");

	a_reject_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(en && res.rejected) |=> ($past(phase_q) != owb_pkg::PH_IDLE))
		else $error("command rejected while idle");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(phase_q) && $stable(timer_q) && $stable(bidx_q)))
		else $error("state moved without a tick");

endmodule
